// ----- rtl/core/nmt_pkg.sv -----
// Package for the NAT mapping table: sizes, entry and command types, codes.
// Used by every file under rtl/core; depends on nothing else.
package nmt_pkg;

   localparam int TableEntries = 64;
   localparam logic [15:0] PortFloor = 16'd1024;
   localparam logic [15:0] PortCeil = 16'hFFFF;
   localparam logic [15:0] TimeoutReset = 16'd60;

   typedef enum logic [1:0] {
      OP_OUTBOUND = 2'd0,
      OP_INBOUND  = 2'd1,
      OP_TICK     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic {
      CSR_EXT_IP  = 1'b0,
      CSR_TIMEOUT = 1'b1
   } csr_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_BUSY = 1'b1
   } state_type;

   // One table entry as held by a cell.
   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [31:0] priv_ip;
      logic [15:0] priv_port;
      logic [31:0] pub_ip;
      logic [15:0] pub_port;
      logic [31:0] stamp;
   } entry_type;

   // Lookup and aging command broadcast to every cell.
   typedef struct packed {
      logic        look;
      logic        outbound;
      logic [31:0] ip;
      logic [15:0] iport;
      logic [15:0] eport;
      logic        kind;
      logic        tick;
      logic [31:0] seconds;
      logic [15:0] timeout;
   } cmd_type;

endpackage

// ----- rtl/core/nat_mapping_table_top.sv -----
// Top level of the NAT mapping table: control, counters and the cell chain.
// Depends on nmt_pkg and nmt_cell.
//
// Usage: items arrive on the req_ stream, results leave on the rsp_ stream.
// Operation 0 (outbound) finds or creates an entry for an internal address,
// port and type; operation 1 (inbound) finds the newest entry with a given
// external port and type. Both give one result beat. Operation 2 is the
// one-second tick: it ages out idle ICMP entries and gives no result.
// Operation 3 is dropped. The csr_ port writes the external address (index 0)
// and the ICMP timeout (index 1); the user must write them only while the block
// is idle, which the block itself does not enforce. Every cell compares in the
// accept cycle and registers a match; in the following cycle (the busy state)
// the chain picks the newest match (or shifts in the new entry) and the result
// is registered. No item is accepted in the busy state, and while the result
// waits the next item is accepted only in a cycle where that result is being taken.
// Reset clears every entry, sets the port counter to 1024, the clock to zero,
// the timeout to 60 and the external address to zero. When the receiver
// stalls, the result holds and req_tready stays low until it is taken.
module nat_mapping_table_top
   import nmt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[1:0], internal_ip[33:2], internal_port[49:34],
   // external_port[65:50], mapping_type[66], zero fill
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // found[0], created[1], table_full[2], result_internal_ip[34:3],
   // result_internal_port[50:35], result_external_ip[82:51],
   // result_external_port[98:83], result_type[99], zero fill
   output logic [103:0] rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata
);

   state_type   state_ff, state_in;
   logic [31:0] ext_ip_ff;
   logic [15:0] timeout_ff;
   logic [15:0] port_ff, port_in;
   logic [31:0] sec_ff, sec_in;
   logic        outbound_ff;
   logic [31:0] ip_ff;
   logic [15:0] iport_ff;
   logic        kind_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [99:0] rsp_data_ff, rsp_data_in;

   logic        accept;
   op_type      req_op;
   cmd_type     cmd;
   logic        do_insert;
   logic        hit;
   logic        full;
   entry_type   new_entry;
   entry_type   picked;

   entry_type   chain_entry [TableEntries+1];
   logic        chain_ok [TableEntries+1];
   logic        chain_seen [TableEntries+1];
   entry_type   sel_bus [TableEntries];

   assign req_op     = op_type'(req_tdata[1:0]);
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

   // Command broadcast to the cells in the accept cycle.
   always_comb begin
      cmd.look     = accept && ((req_op == OP_OUTBOUND) || (req_op == OP_INBOUND));
      cmd.outbound = (req_op == OP_OUTBOUND);
      cmd.ip       = req_tdata[33:2];
      cmd.iport    = req_tdata[49:34];
      cmd.eport    = req_tdata[65:50];
      cmd.kind     = req_tdata[66];
      cmd.tick     = accept && (req_op == OP_TICK);
      cmd.seconds  = sec_ff + 32'd1;
      cmd.timeout  = timeout_ff;
   end

   // New entry built from the held item.
   always_comb begin
      new_entry.valid     = 1'b1;
      new_entry.kind      = kind_ff;
      new_entry.priv_ip   = ip_ff;
      new_entry.priv_port = iport_ff;
      new_entry.pub_ip    = ext_ip_ff;
      new_entry.pub_port  = port_ff;
      new_entry.stamp     = sec_ff;
   end

   assign chain_entry[0] = new_entry;
   assign chain_ok[0]    = 1'b1;
   assign chain_seen[0]  = 1'b0;

   genvar g;
   generate
      for (g = 0; g < TableEntries; g++) begin : g_cell
         nmt_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .shift_en   (do_insert),
            .prev_entry (chain_entry[g]),
            .chain_in   (chain_ok[g]),
            .seen_in    (chain_seen[g]),
            .entry_out  (chain_entry[g+1]),
            .chain_out  (chain_ok[g+1]),
            .seen_out   (chain_seen[g+1]),
            .sel_entry  (sel_bus[g])
         );
      end
   endgenerate

   // Only the newest matching cell drives its entry; OR the bus together.
   always_comb begin
      picked = '0;
      for (int i = 0; i < TableEntries; i++) begin
         picked = picked | sel_bus[i];
      end
   end

   assign hit       = chain_seen[TableEntries];
   assign full      = chain_ok[TableEntries];
   assign do_insert = (state_ff == ST_BUSY) && outbound_ff && !hit && !full;

   // Control: next state, counters and the result register.
   always_comb begin
      state_in     = state_ff;
      port_in      = port_ff;
      sec_in       = sec_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.look) begin
               state_in = ST_BUSY;
            end
            if (cmd.tick) begin
               sec_in = cmd.seconds;
            end
         end
         ST_BUSY: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            if (hit) begin
               rsp_data_in = {picked.kind, picked.pub_port, picked.pub_ip,
                              picked.priv_port, picked.priv_ip, 3'b001};
            end else if (!outbound_ff) begin
               rsp_data_in = '0;
            end else if (full) begin
               rsp_data_in = {97'd0, 3'b100};
            end else begin
               rsp_data_in = {new_entry.kind, new_entry.pub_port, new_entry.pub_ip,
                              new_entry.priv_port, new_entry.priv_ip, 3'b011};
               port_in = (port_ff == PortCeil) ? PortFloor : port_ff + 16'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         port_ff      <= PortFloor;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ext_ip_ff    <= '0;
         timeout_ff   <= TimeoutReset;
      end else begin
         state_ff     <= state_in;
         port_ff      <= port_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_type'(csr_addr))
               CSR_EXT_IP:  ext_ip_ff  <= csr_wdata;
               CSR_TIMEOUT: timeout_ff <= csr_wdata[15:0];
               default:     ext_ip_ff  <= ext_ip_ff;
            endcase
         end
      end
   end

   // Held item and result payload.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         outbound_ff <= cmd.outbound;
         ip_ff       <= cmd.ip;
         iport_ff    <= cmd.iport;
         kind_ff     <= cmd.kind;
      end
   end

endmodule

// ----- rtl/core/nmt_cell.sv -----
// One cell of the mapping table chain: holds one entry, compares it and ages it.
// Depends on nmt_pkg. Cells are ordered newest first; inserts shift toward the end.
module nmt_cell
   import nmt_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      shift_en,
   input  entry_type prev_entry,
   input  logic      chain_in,
   input  logic      seen_in,
   output entry_type entry_out,
   output logic      chain_out,
   output logic      seen_out,
   output entry_type sel_entry
);

   entry_type entry_ff, entry_in;
   logic      match_ff, match_in;
   logic      key_hit;
   logic [31:0] age;

   // Key compare against the broadcast command.
   always_comb begin
      age = cmd.seconds - entry_ff.stamp;
      if (cmd.outbound) begin
         key_hit = (entry_ff.priv_ip == cmd.ip) && (entry_ff.priv_port == cmd.iport);
      end else begin
         key_hit = (entry_ff.pub_port == cmd.eport);
      end
      key_hit = key_hit && entry_ff.valid && (entry_ff.kind == cmd.kind);
   end

   // Next entry: shift from the newer neighbor, or age out on a tick.
   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      if (cmd.look) begin
         match_in = key_hit;
      end
      if (shift_en && chain_in) begin
         entry_in = prev_entry;
         match_in = 1'b0;
      end else if (cmd.tick && entry_ff.valid && !entry_ff.kind &&
                   (age > {16'd0, cmd.timeout})) begin
         entry_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
         match_ff <= match_in;
      end
      entry_ff.kind      <= entry_in.kind;
      entry_ff.priv_ip   <= entry_in.priv_ip;
      entry_ff.priv_port <= entry_in.priv_port;
      entry_ff.pub_ip    <= entry_in.pub_ip;
      entry_ff.pub_port  <= entry_in.pub_port;
      entry_ff.stamp     <= entry_in.stamp;
   end

   // Neighbor links: the insert chain stops at the first free cell, and the
   // first matching cell (the newest) drives its entry onto the result bus.
   assign entry_out = entry_ff;
   assign chain_out = chain_in && entry_ff.valid;
   assign seen_out  = seen_in || match_ff;
   assign sel_entry = (match_ff && !seen_in) ? entry_ff : '0;

endmodule

// ----- tb/sv/tb_nat_mapping_table_top.sv -----
// Self-checking testbench for nat_mapping_table_top: streams lookups and ticks,
// predicts every response beat with a local table model and compares them.
// Depends on nmt_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_nat_mapping_table_top;
   import nmt_pkg::*;

   typedef struct {
      op_type      op;
      logic [31:0] ip;
      logic [15:0] iport;
      logic [15:0] eport;
      logic        kind;
   } nat_req_t;

   typedef struct {
      logic        found;
      logic        created;
      logic        full;
      logic [31:0] iip;
      logic [15:0] iport;
      logic [31:0] eip;
      logic [15:0] eport;
      logic        kind;
   } nat_rsp_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_addr = 1'b0;
   logic [31:0]  csr_wdata = '0;

   nat_mapping_table_top uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow of the translation table.
   logic        tbl_valid [TableEntries];
   logic        tbl_kind [TableEntries];
   logic [31:0] tbl_priv_ip [TableEntries];
   logic [15:0] tbl_priv_port [TableEntries];
   logic [31:0] tbl_pub_ip [TableEntries];
   logic [15:0] tbl_pub_port [TableEntries];
   logic [31:0] tbl_stamp [TableEntries];
   int          tbl_age_rank [TableEntries];
   logic [15:0] port_counter = PortFloor;
   logic [31:0] seconds = '0;
   logic [31:0] shadow_ext_ip = '0;
   logic [15:0] shadow_timeout = TimeoutReset;

   nat_req_t pending_reqs[$];
   nat_rsp_t expected_rsps[$];
   nat_req_t cur_req;
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;
   int       hold_reqs = 0;
   int       hold_done = 0;
   int       hold_cnt = 0;
   int       errors = 0;

   initial begin
      for (int i = 0; i < TableEntries; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_age_rank[i] = 0;
      end
   end

   function automatic nat_rsp_t entry_rsp(int slot, logic created);
      nat_rsp_t r;
      r = '{default: '0};
      r.found = 1'b1;
      r.created = created;
      r.iip = tbl_priv_ip[slot];
      r.iport = tbl_priv_port[slot];
      r.eip = tbl_pub_ip[slot];
      r.eport = tbl_pub_port[slot];
      r.kind = tbl_kind[slot];
      return r;
   endfunction

   // Apply one accepted request beat to the shadow table and queue its response.
   task automatic translate(input nat_req_t q);
      int       hit;
      int       free_slot;
      int       r;
      nat_rsp_t rsp;
      hit = -1;
      free_slot = -1;
      rsp = '{default: '0};
      case (q.op)
         OP_OUTBOUND: begin
            for (int i = 0; i < TableEntries; i++) begin
               if (tbl_valid[i]) begin
                  if (tbl_priv_ip[i] == q.ip && tbl_priv_port[i] == q.iport &&
                      tbl_kind[i] == q.kind &&
                      (hit < 0 || tbl_age_rank[i] < tbl_age_rank[hit]))
                     hit = i;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (hit >= 0) begin
               rsp = entry_rsp(hit, 1'b0);
            end else if (free_slot < 0) begin
               rsp.full = 1'b1;
            end else begin
               for (int i = 0; i < TableEntries; i++)
                  if (tbl_valid[i]) tbl_age_rank[i]++;
               tbl_valid[free_slot] = 1'b1;
               tbl_age_rank[free_slot] = 0;
               tbl_kind[free_slot] = q.kind;
               tbl_priv_ip[free_slot] = q.ip;
               tbl_priv_port[free_slot] = q.iport;
               tbl_pub_ip[free_slot] = shadow_ext_ip;
               tbl_pub_port[free_slot] = port_counter;
               tbl_stamp[free_slot] = seconds;
               port_counter = (port_counter == PortCeil) ? PortFloor : port_counter + 16'd1;
               rsp = entry_rsp(free_slot, 1'b1);
            end
            expected_rsps.push_back(rsp);
         end
         OP_INBOUND: begin
            for (int i = 0; i < TableEntries; i++)
               if (tbl_valid[i] && tbl_pub_port[i] == q.eport && tbl_kind[i] == q.kind &&
                   (hit < 0 || tbl_age_rank[i] < tbl_age_rank[hit]))
                  hit = i;
            if (hit >= 0) rsp = entry_rsp(hit, 1'b0);
            expected_rsps.push_back(rsp);
         end
         OP_TICK: begin
            seconds = seconds + 32'd1;
            for (int i = 0; i < TableEntries; i++) begin
               if (tbl_valid[i] && !tbl_kind[i] &&
                   (seconds - tbl_stamp[i]) > {16'd0, shadow_timeout}) begin
                  r = tbl_age_rank[i];
                  tbl_valid[i] = 1'b0;
                  for (int j = 0; j < TableEntries; j++)
                     if (tbl_valid[j] && tbl_age_rank[j] > r) tbl_age_rank[j]--;
               end
            end
         end
         default: ;
      endcase
   endtask

   // Request driver: predicts on acceptance, then offers the next beat.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) translate(cur_req);
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            cur_req = pending_reqs.pop_front();
            req_tdata <= {5'd0, cur_req.kind, cur_req.eport, cur_req.iport,
                          cur_req.ip, cur_req.op};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted here.
   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_done != hold_reqs) begin
         hold_cnt <= 300;
         hold_done <= hold_done + 1;
      end
   end

   always @(posedge clock) begin
      if (hold_cnt > 0 || hold_done != hold_reqs)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Response monitor.
   always @(posedge clock) begin
      nat_rsp_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsps.size() == 0) begin
            $error("response beat with no request waiting: %h", rsp_tdata);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_tdata[0] !== want.found) begin
               $error("found: expected %h, got %h", want.found, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[1] !== want.created) begin
               $error("created: expected %h, got %h", want.created, rsp_tdata[1]);
               errors++;
            end
            if (rsp_tdata[2] !== want.full) begin
               $error("table_full: expected %h, got %h", want.full, rsp_tdata[2]);
               errors++;
            end
            if (rsp_tdata[34:3] !== want.iip) begin
               $error("result_internal_ip: expected %h, got %h", want.iip, rsp_tdata[34:3]);
               errors++;
            end
            if (rsp_tdata[50:35] !== want.iport) begin
               $error("result_internal_port: expected %h, got %h", want.iport,
                      rsp_tdata[50:35]);
               errors++;
            end
            if (rsp_tdata[82:51] !== want.eip) begin
               $error("result_external_ip: expected %h, got %h", want.eip, rsp_tdata[82:51]);
               errors++;
            end
            if (rsp_tdata[98:83] !== want.eport) begin
               $error("result_external_port: expected %h, got %h", want.eport,
                      rsp_tdata[98:83]);
               errors++;
            end
            if (rsp_tdata[99] !== want.kind) begin
               $error("result_type: expected %h, got %h", want.kind, rsp_tdata[99]);
               errors++;
            end
         end
      end
   end

   task automatic push_req(input op_type op, input logic [31:0] ip, input logic [15:0] iport,
                           input logic [15:0] eport, input logic kind);
      nat_req_t q;
      while (pending_reqs.size() >= 4) @(posedge clock);
      q.op = op;
      q.ip = ip;
      q.iport = iport;
      q.eport = eport;
      q.kind = kind;
      pending_reqs.push_back(q);
   endtask

   // Wait until every beat is accepted and answered.
   task automatic drain();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      if (idx == CSR_EXT_IP) shadow_ext_ip = value;
      else shadow_timeout = value[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // One randomized phase with small key pools so that hits and expiry are common.
   task automatic random_phase(input int count);
      int          pick;
      logic [31:0] ip;
      logic [15:0] port;
      logic        kind;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         kind = 1'($urandom_range(1));
         if (pick < 45) begin
            if (kind) begin
               // TCP entries never age out, so keep their keys to a pool of eight.
               ip = 32'h0A00_0000 + $urandom_range(3);
               port = 16'd8000 + 16'($urandom_range(1));
            end else if ($urandom_range(99) < 70) begin
               ip = 32'h0A01_0000 + $urandom_range(7);
               port = 16'($urandom_range(4));
            end else begin
               ip = $urandom;
               port = 16'($urandom);
            end
            push_req(OP_OUTBOUND, ip, port, 16'($urandom), kind);
         end else if (pick < 82) begin
            if ($urandom_range(99) < 80)
               port = port_counter - 16'($urandom_range(1, 40));
            else
               port = 16'($urandom);
            push_req(OP_INBOUND, $urandom, 16'($urandom), port, kind);
         end else if (pick < 96) begin
            push_req(OP_TICK, $urandom, 16'($urandom), 16'($urandom), kind);
         end else begin
            push_req(OP_NONE, $urandom, 16'($urandom), 16'($urandom), kind);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: create, hit, inbound hit and miss, field extremes, tick, unused op.
      push_req(OP_OUTBOUND, 32'hC0A8_0001, 16'd5000, 16'd0, 1'b0);
      push_req(OP_OUTBOUND, 32'hC0A8_0001, 16'd5000, 16'd0, 1'b0);
      push_req(OP_OUTBOUND, 32'hC0A8_0001, 16'd5000, 16'd0, 1'b1);
      push_req(OP_OUTBOUND, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      push_req(OP_OUTBOUND, 32'h0000_0000, 16'h0000, 16'h0000, 1'b0);
      push_req(OP_INBOUND, 32'h0, 16'h0, 16'd1024, 1'b0);
      push_req(OP_INBOUND, 32'h0, 16'h0, 16'd1024, 1'b1);
      push_req(OP_INBOUND, 32'hFFFF_FFFF, 16'hFFFF, 16'd1026, 1'b1);
      push_req(OP_INBOUND, 32'h0, 16'h0, 16'hFFFF, 1'b0);
      push_req(OP_INBOUND, 32'h0, 16'h0, 16'h0000, 1'b1);
      push_req(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      push_req(OP_TICK, 32'h0, 16'h0, 16'h0, 1'b0);
      push_req(OP_INBOUND, 32'h0, 16'h0, 16'd1027, 1'b0);
      drain();

      // Fill the table with ICMP entries past capacity, then age them out.
      write_csr(CSR_EXT_IP, 32'hFFFF_FFFF);
      write_csr(CSR_TIMEOUT, 32'd0);
      for (int i = 0; i < 70; i++)
         push_req(OP_OUTBOUND, 32'h0B00_0000 + i, 16'(i), 16'd0, 1'b0);
      push_req(OP_INBOUND, 32'h0, 16'h0, port_counter - 16'd1, 1'b0);
      push_req(OP_TICK, 32'h0, 16'h0, 16'h0, 1'b0);
      push_req(OP_INBOUND, 32'h0, 16'h0, port_counter - 16'd1, 1'b0);
      drain();

      // Random phases with different idling and settings.
      write_csr(CSR_EXT_IP, $urandom);
      write_csr(CSR_TIMEOUT, 32'd5);
      random_phase(450);
      drain();

      send_idle_pct = 82;
      write_csr(CSR_EXT_IP, 32'h0000_0000);
      write_csr(CSR_TIMEOUT, 32'd2);
      random_phase(450);
      drain();

      send_idle_pct = 0;
      recv_stall_pct = 82;
      write_csr(CSR_EXT_IP, $urandom);
      write_csr(CSR_TIMEOUT, 32'd8);
      hold_reqs = hold_reqs + 1;
      random_phase(450);
      drain();

      send_idle_pct = 22;
      recv_stall_pct = 22;
      write_csr(CSR_EXT_IP, 32'hFFFF_FFFF);
      write_csr(CSR_TIMEOUT, 32'h0000_FFFF);
      random_phase(450);
      drain();

      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog.
   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/nmt_pkg.sv
rtl/core/nmt_cell.sv
rtl/core/nat_mapping_table_top.sv
tb/sv/tb_nat_mapping_table_top.sv
